@@ design/thermistor_divider_to_temperature_assert.svh @@
// Assertion macros used by the thermistor conversion RTL.
// No dependencies; included by the modules that carry assertions.
`ifndef THERMISTOR_DIVIDER_TO_TEMPERATURE_ASSERT_SVH
`define THERMISTOR_DIVIDER_TO_TEMPERATURE_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define TDT_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define TDT_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ design/tdt_pkg.sv @@
// Shared types and constants for the thermistor divider to temperature block.
// No dependencies.
package tdt_pkg;

    localparam int MV_W       = 16;
    localparam int RS_W       = 24;
    localparam int VR_W       = 16;
    localparam int COEF_W     = 48;
    localparam int TEMP_W     = 32;
    localparam int RES_W      = 32;
    localparam int STAT_W     = 3;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 48;
    localparam int NUM_W      = 42;   // 2*mv*Rs + d
    localparam int DEN_W      = 17;   // 2*d
    localparam int FIFO_DEPTH = 4;
    localparam int FIFO_PTR_W = 2;
    localparam int FIFO_CNT_W = 3;

    localparam logic [63:0] LN2_Q64     = 64'hB17217F7D1CF79AC;
    localparam logic [16:0] HALF_OFFSET = 17'd54629;

    typedef logic [STAT_W-1:0] t_status;
    localparam t_status ST_OK       = 3'd0;
    localparam t_status ST_NO_COEFF = 3'd1;
    localparam t_status ST_ZERO_REF = 3'd2;
    localparam t_status ST_HIGH_MV  = 3'd3;
    localparam t_status ST_BAD_R    = 3'd4;

    typedef logic [CFG_IDX_W-1:0] t_cfg_idx;
    localparam t_cfg_idx CFG_SERIES_R = 3'd0;
    localparam t_cfg_idx CFG_REF_MV   = 3'd1;
    localparam t_cfg_idx CFG_COEFF_A  = 3'd2;
    localparam t_cfg_idx CFG_COEFF_B  = 3'd3;
    localparam t_cfg_idx CFG_COEFF_C  = 3'd4;
    localparam t_cfg_idx CFG_VALID    = 3'd5;

    typedef struct packed {
        logic [RS_W-1:0]          rs;
        logic [VR_W-1:0]          vr;
        logic signed [COEF_W-1:0] a;
        logic signed [COEF_W-1:0] b;
        logic signed [COEF_W-1:0] c;
        logic                     valid;
    } t_cfg;

    typedef struct packed {
        t_status          status;
        logic [NUM_W-1:0] num;
        logic [DEN_W-1:0] den2;
    } t_job;

endpackage

@@ design/tdt_front.sv @@
// Front end: classify each sample and form the resistance division operands.
// Depends on tdt_pkg.
module tdt_front (
    input  tdt_pkg::t_cfg              i_cfg,
    input  logic [tdt_pkg::MV_W-1:0]   i_mv,
    input  logic                       i_push,
    input  logic                       i_full,
    output logic                       o_wr,
    output tdt_pkg::t_job              o_job
);

    logic [tdt_pkg::VR_W-1:0] w_vr_m1;
    logic [tdt_pkg::VR_W-1:0] w_d;
    logic [39:0]              w_prod;

    assign o_wr    = i_push && !i_full;
    assign w_vr_m1 = i_cfg.vr - 16'd1;
    assign w_d     = i_cfg.vr - i_mv;
    assign w_prod  = 40'(i_mv) * 40'(i_cfg.rs);

    always_comb begin
        priority if (!i_cfg.valid) begin
            o_job.status = tdt_pkg::ST_NO_COEFF;
        end else if (i_cfg.vr == '0 || i_cfg.rs == '0) begin
            o_job.status = tdt_pkg::ST_ZERO_REF;
        end else if (i_mv >= w_vr_m1) begin
            o_job.status = tdt_pkg::ST_HIGH_MV;
        end else begin
            o_job.status = tdt_pkg::ST_OK;
        end
        // Round half up: (2*mv*Rs + d) / (2*d)
        o_job.num  = tdt_pkg::NUM_W'({w_prod, 1'b0}) + tdt_pkg::NUM_W'(w_d);
        o_job.den2 = {w_d, 1'b0};
    end

endmodule

@@ design/tdt_fifo.sv @@
// Short queue of classified jobs between the front end and the pipeline.
// Depends on tdt_pkg.
module tdt_fifo (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_wr,
    input  tdt_pkg::t_job i_job,
    output logic          o_full,
    input  logic          i_rd,
    output tdt_pkg::t_job o_job,
    output logic          o_empty
);

    tdt_pkg::t_job                    r_mem [0:tdt_pkg::FIFO_DEPTH-1];
    logic [tdt_pkg::FIFO_PTR_W-1:0]   r_wr_ptr;
    logic [tdt_pkg::FIFO_PTR_W-1:0]   r_rd_ptr;
    logic [tdt_pkg::FIFO_CNT_W-1:0]   r_count;
    logic                             w_do_rd;

    assign o_full  = (r_count == tdt_pkg::FIFO_CNT_W'(tdt_pkg::FIFO_DEPTH));
    assign o_empty = (r_count == '0);
    assign o_job   = r_mem[r_rd_ptr];
    assign w_do_rd = i_rd && !o_empty;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_wr) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (w_do_rd) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            r_count <= r_count + tdt_pkg::FIFO_CNT_W'(i_wr) - tdt_pkg::FIFO_CNT_W'(w_do_rd);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_wr) begin
            r_mem[r_wr_ptr] <= i_job;
        end
    end

endmodule

@@ design/tdt_back.sv @@
// Back end pipeline: resistance divider, log2 by squaring, Steinhart-Hart
// polynomial, reciprocal divider and output register. Depends on tdt_pkg.
`include "thermistor_divider_to_temperature_assert.svh"
module tdt_back #(
    parameter int COEFF_FRAC_BITS = 50
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  tdt_pkg::t_cfg               i_cfg,
    input  tdt_pkg::t_job               i_job,
    input  logic                        i_job_valid,
    output logic                        o_job_take,
    input  logic                        i_pop,
    output logic                        o_empty,
    output logic [tdt_pkg::TEMP_W-1:0]  o_temp,
    output logic [tdt_pkg::RES_W-1:0]   o_res,
    output tdt_pkg::t_status            o_status
);

    localparam int NUM_W = tdt_pkg::NUM_W;
    localparam int DEN_W = tdt_pkg::DEN_W;
    localparam int NW    = COEFF_FRAC_BITS + 8;
    localparam logic [NW-1:0] TWO_N = NW'(200) << COEFF_FRAC_BITS;

    logic en;

    // ---------------- resistance divider ----------------
    logic                 r_rv   [0:NUM_W];
    tdt_pkg::t_status     r_rst  [0:NUM_W];
    logic [NUM_W-1:0]     r_rnq  [0:NUM_W];
    logic [DEN_W-1:0]     r_rrem [0:NUM_W];
    logic [DEN_W-1:0]     r_rden [0:NUM_W];
    logic [DEN_W:0]       w_rsh  [0:NUM_W-1];
    logic                 w_rge  [0:NUM_W-1];
    logic [NUM_W-1:0]     n_rnq  [0:NUM_W-1];
    logic [DEN_W-1:0]     n_rrem [0:NUM_W-1];

    // ---------------- normalize ----------------
    logic             r_n1_v, r_n2_v;
    tdt_pkg::t_status r_n1_st, r_n2_st, n_n1_st;
    logic [31:0]      r_n1_res, r_n2_res, n_n1_res;
    logic [4:0]       r_n2_k, n_n2_k;

    // ---------------- log2 squaring ----------------
    logic             r_gv   [0:32];
    tdt_pkg::t_status r_gst  [0:32];
    logic [31:0]      r_gres [0:32];
    logic [4:0]       r_gk   [0:32];
    logic [31:0]      r_gm   [0:32];
    logic [31:0]      r_gf   [0:32];
    logic [63:0]      w_gsq  [0:31];
    logic [32:0]      w_gs   [0:31];
    logic [31:0]      n_gm   [0:31];
    logic [31:0]      n_gf   [0:31];

    // ---------------- polynomial ----------------
    logic             r_l1_v, r_l2_v, r_q1_v, r_q2_v, r_c1_v, r_c2_v, r_e1_v, r_e2_v;
    tdt_pkg::t_status r_l1_st, r_l2_st, r_q1_st, r_q2_st, r_c1_st, r_c2_st, r_e1_st, r_e2_st;
    logic [31:0]      r_l1_res, r_l2_res, r_q1_res, r_q2_res;
    logic [31:0]      r_c1_res, r_c2_res, r_e1_res, r_e2_res;
    logic [68:0]      r_l1_plo, r_l1_phi;
    logic [100:0]     w_l2_prod;
    logic [36:0]      r_l2_l, r_q1_l, r_q2_l;
    logic [68:0]      r_q1_a0;
    logic [41:0]      r_q1_a1;
    logic [60:0]      r_q1_b0, r_q1_b1;
    logic [47:0]      w_bm, w_cm;
    logic [73:0]      w_q2_sq;
    logic [84:0]      w_q2_bp;
    logic [52:0]      w_q2_blm;
    logic [41:0]      r_q2_l2;
    logic [63:0]      r_q2_bl, r_c1_bl, r_c2_bl, r_e1_bl, r_e2_bl;
    logic [68:0]      r_c1_p0;
    logic [46:0]      r_c1_p1;
    logic [78:0]      w_c2_s;
    logic [46:0]      r_c2_l3;
    logic [70:0]      r_e1_p0, r_e1_p1;
    logic [94:0]      w_e2_s;
    logic [62:0]      w_e2_clm;
    logic [63:0]      r_e2_cl;
    logic signed [63:0] w_v;
    tdt_pkg::t_status n_z_st;

    // ---------------- reciprocal divider ----------------
    logic             r_zv   [0:NW];
    tdt_pkg::t_status r_zst  [0:NW];
    logic [31:0]      r_zres [0:NW];
    logic [NW-1:0]    r_znq  [0:NW];
    logic [62:0]      r_zrem [0:NW];
    logic [62:0]      r_zden [0:NW];
    logic [63:0]      w_zsh  [0:NW-1];
    logic             w_zge  [0:NW-1];
    logic [NW-1:0]    n_znq  [0:NW-1];
    logic [62:0]      n_zrem [0:NW-1];

    // ---------------- output ----------------
    logic             w_hi;
    logic [NW-1:0]    w_p;
    logic [31:0]      w_tp, w_tn, w_t;
    logic [16:0]      w_zc, w_tn_mag;
    logic             r_out_v;
    tdt_pkg::t_status r_out_st;
    logic [31:0]      r_out_temp, r_out_res;

    // Advance the whole pipeline unless a result is waiting and not taken.
    assign en         = !r_out_v || i_pop;
    assign o_job_take = en && i_job_valid;
    assign o_empty    = !r_out_v;
    assign o_temp     = r_out_temp;
    assign o_res      = r_out_res;
    assign o_status   = r_out_st;

    always_comb begin
        for (int i = 0; i < NUM_W; i++) begin
            w_rsh[i]  = {r_rrem[i], r_rnq[i][NUM_W-1]};
            w_rge[i]  = (w_rsh[i] >= {1'b0, r_rden[i]});
            n_rrem[i] = w_rge[i] ? DEN_W'(w_rsh[i] - {1'b0, r_rden[i]}) : w_rsh[i][DEN_W-1:0];
            n_rnq[i]  = {r_rnq[i][NUM_W-2:0], w_rge[i]};
        end
    end

    always_comb begin
        n_n1_res = (|r_rnq[NUM_W][NUM_W-1:32]) ? 32'hFFFFFFFF : r_rnq[NUM_W][31:0];
        n_n1_st  = (r_rst[NUM_W] == tdt_pkg::ST_OK && n_n1_res == '0) ?
                   tdt_pkg::ST_BAD_R : r_rst[NUM_W];
        n_n2_k   = '0;
        for (int j = 0; j < 32; j++) begin
            if (r_n1_res[j]) begin
                n_n2_k = 5'(j);
            end
        end
    end

    always_comb begin
        for (int i = 0; i < 32; i++) begin
            w_gsq[i] = 64'(r_gm[i]) * 64'(r_gm[i]);
            w_gs[i]  = w_gsq[i][63:31];
            n_gm[i]  = w_gs[i][32] ? w_gs[i][32:1] : w_gs[i][31:0];
            n_gf[i]  = {r_gf[i][30:0], w_gs[i][32]};
        end
    end

    always_comb begin
        w_l2_prod = {r_l1_phi, 32'b0} + 101'(r_l1_plo);
        w_bm      = i_cfg.b[47] ? (~i_cfg.b + 48'd1) : i_cfg.b;
        w_cm      = i_cfg.c[47] ? (~i_cfg.c + 48'd1) : i_cfg.c;
        w_q2_sq   = 74'(r_q1_a0) + {r_q1_a1, 32'b0} + 74'h80000000;
        w_q2_bp   = 85'(r_q1_b0) + {r_q1_b1, 24'b0} + 85'h80000000;
        w_q2_blm  = w_q2_bp[84:32];
        w_c2_s    = 79'(r_c1_p0) + {r_c1_p1, 32'b0} + 79'h80000000;
        w_e2_s    = 95'(r_e1_p0) + {r_e1_p1, 24'b0} + 95'h80000000;
        w_e2_clm  = w_e2_s[94:32];
        w_v       = $signed({{16{i_cfg.a[47]}}, i_cfg.a}) + $signed(r_e2_bl) + $signed(r_e2_cl);
        n_z_st    = (r_e2_st == tdt_pkg::ST_OK && (w_v[63] || w_v == '0)) ?
                    tdt_pkg::ST_BAD_R : r_e2_st;
    end

    always_comb begin
        for (int i = 0; i < NW; i++) begin
            w_zsh[i]  = {r_zrem[i], r_znq[i][NW-1]};
            w_zge[i]  = (w_zsh[i] >= {1'b0, r_zden[i]});
            n_zrem[i] = w_zge[i] ? 63'(w_zsh[i] - {1'b0, r_zden[i]}) : w_zsh[i][62:0];
            n_znq[i]  = {r_znq[i][NW-2:0], w_zge[i]};
        end
    end

    always_comb begin
        w_hi     = (r_znq[NW] >= NW'(tdt_pkg::HALF_OFFSET));
        w_p      = (r_znq[NW] - NW'(tdt_pkg::HALF_OFFSET)) >> 1;
        w_tp     = (|w_p[NW-1:31]) ? 32'h7FFFFFFF : {1'b0, w_p[30:0]};
        w_zc     = r_znq[NW][16:0] + 17'(|r_zrem[NW]);
        w_tn_mag = (tdt_pkg::HALF_OFFSET - w_zc) >> 1;
        w_tn     = 32'd0 - 32'(w_tn_mag);
        w_t      = w_hi ? w_tp : w_tn;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i <= NUM_W; i++) r_rv[i] <= 1'b0;
            for (int i = 0; i <= 32; i++)    r_gv[i] <= 1'b0;
            for (int i = 0; i <= NW; i++)    r_zv[i] <= 1'b0;
            r_n1_v <= 1'b0; r_n2_v <= 1'b0;
            r_l1_v <= 1'b0; r_l2_v <= 1'b0; r_q1_v <= 1'b0; r_q2_v <= 1'b0;
            r_c1_v <= 1'b0; r_c2_v <= 1'b0; r_e1_v <= 1'b0; r_e2_v <= 1'b0;
            r_out_v <= 1'b0;
        end else if (en) begin
            r_rv[0] <= i_job_valid;
            for (int i = 0; i < NUM_W; i++) r_rv[i+1] <= r_rv[i];
            r_n1_v  <= r_rv[NUM_W];
            r_n2_v  <= r_n1_v;
            r_gv[0] <= r_n2_v;
            for (int i = 0; i < 32; i++) r_gv[i+1] <= r_gv[i];
            r_l1_v <= r_gv[32];
            r_l2_v <= r_l1_v; r_q1_v <= r_l2_v; r_q2_v <= r_q1_v;
            r_c1_v <= r_q2_v; r_c2_v <= r_c1_v; r_e1_v <= r_c2_v; r_e2_v <= r_e1_v;
            r_zv[0] <= r_e2_v;
            for (int i = 0; i < NW; i++) r_zv[i+1] <= r_zv[i];
            r_out_v <= r_zv[NW];
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_rnq[0]  <= i_job.num;
            r_rrem[0] <= '0;
            r_rden[0] <= i_job.den2;
            r_rst[0]  <= i_job.status;
            for (int i = 0; i < NUM_W; i++) begin
                r_rnq[i+1]  <= n_rnq[i];
                r_rrem[i+1] <= n_rrem[i];
                r_rden[i+1] <= r_rden[i];
                r_rst[i+1]  <= r_rst[i];
            end

            r_n1_res <= n_n1_res;
            r_n1_st  <= n_n1_st;
            r_n2_res <= r_n1_res;
            r_n2_st  <= r_n1_st;
            r_n2_k   <= n_n2_k;

            r_gm[0]   <= r_n2_res << (5'd31 - r_n2_k);
            r_gf[0]   <= '0;
            r_gk[0]   <= r_n2_k;
            r_gres[0] <= r_n2_res;
            r_gst[0]  <= r_n2_st;
            for (int i = 0; i < 32; i++) begin
                r_gm[i+1]   <= n_gm[i];
                r_gf[i+1]   <= n_gf[i];
                r_gk[i+1]   <= r_gk[i];
                r_gres[i+1] <= r_gres[i];
                r_gst[i+1]  <= r_gst[i];
            end

            r_l1_plo <= 69'({r_gk[32], r_gf[32]}) * 69'(tdt_pkg::LN2_Q64[31:0]);
            r_l1_phi <= 69'({r_gk[32], r_gf[32]}) * 69'(tdt_pkg::LN2_Q64[63:32]);
            r_l1_res <= r_gres[32];
            r_l1_st  <= r_gst[32];

            r_l2_l   <= w_l2_prod[100:64] + 37'(w_l2_prod[63]);
            r_l2_res <= r_l1_res;
            r_l2_st  <= r_l1_st;

            r_q1_a0  <= 69'(r_l2_l) * 69'(r_l2_l[31:0]);
            r_q1_a1  <= 42'(r_l2_l) * 42'(r_l2_l[36:32]);
            r_q1_b0  <= 61'(w_bm[23:0]) * 61'(r_l2_l);
            r_q1_b1  <= 61'(w_bm[47:24]) * 61'(r_l2_l);
            r_q1_l   <= r_l2_l;
            r_q1_res <= r_l2_res;
            r_q1_st  <= r_l2_st;

            r_q2_l2  <= w_q2_sq[73:32];
            r_q2_bl  <= i_cfg.b[47] ? (64'd0 - {11'd0, w_q2_blm}) : {11'd0, w_q2_blm};
            r_q2_l   <= r_q1_l;
            r_q2_res <= r_q1_res;
            r_q2_st  <= r_q1_st;

            r_c1_p0  <= 69'(r_q2_l2[31:0]) * 69'(r_q2_l);
            r_c1_p1  <= 47'(r_q2_l2[41:32]) * 47'(r_q2_l);
            r_c1_bl  <= r_q2_bl;
            r_c1_res <= r_q2_res;
            r_c1_st  <= r_q2_st;

            r_c2_l3  <= w_c2_s[78:32];
            r_c2_bl  <= r_c1_bl;
            r_c2_res <= r_c1_res;
            r_c2_st  <= r_c1_st;

            r_e1_p0  <= 71'(w_cm[23:0]) * 71'(r_c2_l3);
            r_e1_p1  <= 71'(w_cm[47:24]) * 71'(r_c2_l3);
            r_e1_bl  <= r_c2_bl;
            r_e1_res <= r_c2_res;
            r_e1_st  <= r_c2_st;

            r_e2_cl  <= i_cfg.c[47] ? (64'd0 - {1'b0, w_e2_clm}) : {1'b0, w_e2_clm};
            r_e2_bl  <= r_e1_bl;
            r_e2_res <= r_e1_res;
            r_e2_st  <= r_e1_st;

            r_znq[0]  <= TWO_N;
            r_zrem[0] <= '0;
            r_zden[0] <= w_v[62:0];
            r_zres[0] <= r_e2_res;
            r_zst[0]  <= n_z_st;
            for (int i = 0; i < NW; i++) begin
                r_znq[i+1]  <= n_znq[i];
                r_zrem[i+1] <= n_zrem[i];
                r_zden[i+1] <= r_zden[i];
                r_zres[i+1] <= r_zres[i];
                r_zst[i+1]  <= r_zst[i];
            end

            r_out_st   <= r_zst[NW];
            r_out_temp <= (r_zst[NW] == tdt_pkg::ST_OK) ? w_t : '0;
            r_out_res  <= (r_zst[NW] == tdt_pkg::ST_OK || r_zst[NW] == tdt_pkg::ST_BAD_R) ?
                          r_zres[NW] : '0;
        end
    end

    `TDT_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, r_out_v && !i_pop, r_out_v && $stable(r_out_temp) && $stable(r_out_st), "result changed while stalled")
    `TDT_ASSERT_IMPL(a_err_temp_zero, i_clk, i_rst_n, r_out_v && r_out_st != tdt_pkg::ST_OK, r_out_temp == '0, "temperature nonzero on error")
    `TDT_ASSERT_IMPL(a_early_err_res, i_clk, i_rst_n, r_out_v && (r_out_st == tdt_pkg::ST_NO_COEFF || r_out_st == tdt_pkg::ST_ZERO_REF || r_out_st == tdt_pkg::ST_HIGH_MV), r_out_res == '0, "resistance nonzero on early error")
    `TDT_ASSERT_IMPL(a_temp_floor, i_clk, i_rst_n, r_out_v && r_out_st == tdt_pkg::ST_OK, $signed(r_out_temp) >= -32'sd27314, "temperature below absolute zero")

endmodule

@@ design/thermistor_divider_to_temperature.sv @@
// Thermistor divider to temperature converter. Every sample pushed becomes one result
// transaction: R = mv*Rs/(Vref-mv) rounded and saturated to 32 bits, then Steinhart-Hart
// 1/T = A + B*lnR + C*lnR^3 with coefficients scaled by 2^-COEFF_FRAC_BITS, giving the
// temperature in hundredths of a degree C and a status code (0 ok, 1 no coefficients,
// 2 reference or resistor zero, 3 voltage at or above reference minus one, 4 resistance
// zero or 1/T not positive). One sample is taken per clock while the queue is not full.
// Each result passes through the bit-per-stage resistance divider, the 32 log2 squaring
// stages, the polynomial multipliers and the bit-per-stage reciprocal divider. When the
// output is not popped the pipeline holds, and a four-entry queue in front of it keeps
// push open a while.
// Write configuration only while the block is idle.
// Top level; depends on tdt_pkg, tdt_front, tdt_fifo and tdt_back.
module thermistor_divider_to_temperature #(
    parameter int COEFF_FRAC_BITS = 50
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              push,
    output logic                              full,
    input  logic [tdt_pkg::MV_W-1:0]          i_divider_millivolts,
    output logic                              empty,
    input  logic                              pop,
    output logic signed [tdt_pkg::TEMP_W-1:0] o_temperature_centi_c,
    output logic [tdt_pkg::RES_W-1:0]         o_resistance_ohms,
    output logic [tdt_pkg::STAT_W-1:0]        o_status,
    input  logic                              i_cfg_we,
    input  logic [tdt_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  logic [tdt_pkg::CFG_DATA_W-1:0]    i_cfg_data
);

    tdt_pkg::t_cfg   r_cfg;
    tdt_pkg::t_job   w_front_job, w_fifo_job;
    logic            w_wr, w_fifo_empty, w_take;
    logic [tdt_pkg::TEMP_W-1:0] w_temp;

    // Configuration registers: write-only, masked to each register width.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.rs    <= 24'd10000;
            r_cfg.vr    <= 16'd3300;
            r_cfg.a     <= '0;
            r_cfg.b     <= '0;
            r_cfg.c     <= '0;
            r_cfg.valid <= 1'b0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                tdt_pkg::CFG_SERIES_R: r_cfg.rs    <= i_cfg_data[23:0];
                tdt_pkg::CFG_REF_MV:   r_cfg.vr    <= i_cfg_data[15:0];
                tdt_pkg::CFG_COEFF_A:  r_cfg.a     <= $signed(i_cfg_data);
                tdt_pkg::CFG_COEFF_B:  r_cfg.b     <= $signed(i_cfg_data);
                tdt_pkg::CFG_COEFF_C:  r_cfg.c     <= $signed(i_cfg_data);
                tdt_pkg::CFG_VALID:    r_cfg.valid <= i_cfg_data[0];
                default: begin
                    // Drop writes to unused indexes.
                end
            endcase
        end
    end

    // Classify the sample and form the division operands as it is pushed.
    tdt_front u_front (
        .i_cfg  (r_cfg),
        .i_mv   (i_divider_millivolts),
        .i_push (push),
        .i_full (full),
        .o_wr   (w_wr),
        .o_job  (w_front_job)
    );

    // Hold classified jobs so input keeps flowing while the output stalls.
    tdt_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_wr    (w_wr),
        .i_job   (w_front_job),
        .o_full  (full),
        .i_rd    (w_take),
        .o_job   (w_fifo_job),
        .o_empty (w_fifo_empty)
    );

    // Arithmetic pipeline with the result register at its end.
    tdt_back #(
        .COEFF_FRAC_BITS (COEFF_FRAC_BITS)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (r_cfg),
        .i_job       (w_fifo_job),
        .i_job_valid (!w_fifo_empty),
        .o_job_take  (w_take),
        .i_pop       (pop),
        .o_empty     (empty),
        .o_temp      (w_temp),
        .o_res       (o_resistance_ohms),
        .o_status    (o_status)
    );

    assign o_temperature_centi_c = $signed(w_temp);

endmodule

@@ tb/sv/thermistor_divider_to_temperature_test.sv @@
`timescale 1ns / 100ps
// Testbench for the thermistor divider to temperature converter: directed and random samples,
// with the expected temperature, resistance and status worked out in fixed point alongside.
// Depends on tdt_pkg and the thermistor_divider_to_temperature RTL.
module thermistor_divider_to_temperature_test;

    localparam int FRAC = 50;
    // Nominal 10k NTC coefficients scaled by 2^50.
    localparam logic [47:0] NOM_A = 48'd1271280000000;
    localparam logic [47:0] NOM_B = 48'd263600000000;
    localparam logic [47:0] NOM_C = 48'd98712000;

    typedef struct packed {
        logic signed [tdt_pkg::TEMP_W-1:0] temp;
        logic [tdt_pkg::RES_W-1:0]         res;
        tdt_pkg::t_status                  status;
    } t_reading;

    // Holds a copy of the register file, turns every accepted sample into the reading it
    // must produce, and matches readings leaving the block against them in order.
    class temp_scoreboard;
        logic [tdt_pkg::RS_W-1:0]   rs;
        logic [tdt_pkg::VR_W-1:0]   vr;
        logic [tdt_pkg::COEF_W-1:0] ca, cb, cc;
        bit                         cv;
        t_reading                   readings_due[$];
        int                         mismatches;

        function new();
            rs = 10000;
            vr = 3300;
            ca = '0;
            cb = '0;
            cc = '0;
            cv = 0;
            mismatches = 0;
        endfunction

        function void write_reg(tdt_pkg::t_cfg_idx idx, logic [tdt_pkg::CFG_DATA_W-1:0] d);
            unique case (idx)
                tdt_pkg::CFG_SERIES_R: rs = d[tdt_pkg::RS_W-1:0];
                tdt_pkg::CFG_REF_MV:   vr = d[tdt_pkg::VR_W-1:0];
                tdt_pkg::CFG_COEFF_A:  ca = d[tdt_pkg::COEF_W-1:0];
                tdt_pkg::CFG_COEFF_B:  cb = d[tdt_pkg::COEF_W-1:0];
                tdt_pkg::CFG_COEFF_C:  cc = d[tdt_pkg::COEF_W-1:0];
                tdt_pkg::CFG_VALID:    cv = d[0];
                default: ;
            endcase
        endfunction

        // Natural log in Q.32: log2 by repeated squaring, then times ln2 in Q.64.
        function logic [63:0] ln_q32(logic [31:0] r);
            int k;
            logic [63:0] m, frac;
            logic [127:0] prod;
            k = 31;
            while (k > 0 && !r[k])
                k--;
            m = {32'b0, r} << (31 - k);
            frac = '0;
            for (int i = 0; i < 32; i++) begin
                m = (m * m) >> 31;
                frac = frac << 1;
                if (m >= 64'h1_0000_0000) begin
                    frac[0] = 1'b1;
                    m = m >> 1;
                end
            end
            prod = {64'b0, (64'(k) << 32) | frac} * {64'b0, tdt_pkg::LN2_Q64};
            return prod[127:64] + 64'(prod[63]);
        endfunction

        // a*b/2^32, rounded half away from zero.
        function longint mul_q32(longint a, logic [63:0] b);
            logic [63:0] mag;
            logic [127:0] p;
            logic [63:0] r;
            mag = (a < 0) ? 64'(-a) : 64'(a);
            p = {64'b0, mag} * {64'b0, b} + 128'h8000_0000;
            r = p[95:32];
            return (a < 0) ? -$signed(r) : $signed(r);
        endfunction

        function t_reading convert(logic [tdt_pkg::MV_W-1:0] mv);
            t_reading o;
            logic [63:0] d, r64, lnr, l2, l3, two_n, zf, rem, p, zc;
            logic [31:0] r;
            longint v;
            o = '0;
            if (!cv) begin
                o.status = tdt_pkg::ST_NO_COEFF;
                return o;
            end
            if (vr == 0 || rs == 0) begin
                o.status = tdt_pkg::ST_ZERO_REF;
                return o;
            end
            if (64'(mv) >= 64'(vr) - 1) begin
                o.status = tdt_pkg::ST_HIGH_MV;
                return o;
            end
            d = 64'(vr) - 64'(mv);
            r64 = (2 * 64'(mv) * 64'(rs) + d) / (2 * d);
            r = (r64 > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : r64[31:0];
            o.res = r;
            if (r == 0) begin
                o.status = tdt_pkg::ST_BAD_R;
                return o;
            end
            lnr = ln_q32(r);
            l2 = mul_q32(longint'(lnr), lnr);
            l3 = mul_q32(longint'(l2), lnr);
            v = longint'($signed(ca)) + mul_q32(longint'($signed(cb)), lnr)
                + mul_q32(longint'($signed(cc)), l3);
            if (v <= 0) begin
                o.status = tdt_pkg::ST_BAD_R;
                return o;
            end
            two_n = 64'd200 << FRAC;
            zf = two_n / 64'(v);
            rem = two_n % 64'(v);
            if (zf >= 64'(tdt_pkg::HALF_OFFSET)) begin
                p = (zf - 64'(tdt_pkg::HALF_OFFSET)) / 2;
                o.temp = (p > 64'd2147483647) ? 32'sd2147483647 : p[31:0];
            end else begin
                zc = zf + ((rem != 0) ? 64'd1 : 64'd0);
                p = (64'(tdt_pkg::HALF_OFFSET) - zc) / 2;
                o.temp = -$signed(p[31:0]);
            end
            o.status = tdt_pkg::ST_OK;
            return o;
        endfunction

        function void note_sample(logic [tdt_pkg::MV_W-1:0] mv);
            readings_due.push_back(convert(mv));
        endfunction

        function void check_result(t_reading got);
            t_reading want;
            if (readings_due.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("Result with nothing outstanding: temp %0d res %0d status %0d",
                             got.temp, got.res, got.status);
                return;
            end
            want = readings_due.pop_front();
            if (got !== want) begin
                mismatches++;
                if (mismatches <= 10)
                    $display({"Mismatch: expected temp %0d res %0d status %0d, ",
                              "got temp %0d res %0d status %0d"},
                             want.temp, want.res, want.status,
                             got.temp, got.res, got.status);
            end
        endfunction
    endclass

    logic                              i_clk = 1'b0;
    logic                              i_rst_n = 1'b0;
    logic                              push = 1'b0;
    logic                              full;
    logic [tdt_pkg::MV_W-1:0]          i_divider_millivolts = '0;
    logic                              empty;
    logic                              pop = 1'b0;
    logic signed [tdt_pkg::TEMP_W-1:0] o_temperature_centi_c;
    logic [tdt_pkg::RES_W-1:0]         o_resistance_ohms;
    logic [tdt_pkg::STAT_W-1:0]        o_status;
    logic                              i_cfg_we = 1'b0;
    logic [tdt_pkg::CFG_IDX_W-1:0]     i_cfg_index = '0;
    logic [tdt_pkg::CFG_DATA_W-1:0]    i_cfg_data = '0;

    temp_scoreboard sb = new();
    int burst_left = 1;
    int pop_mode = 0;
    int pop_mode_left = 0;

    thermistor_divider_to_temperature #(.COEFF_FRAC_BITS(FRAC)) dut (
        .i_clk                 (i_clk),
        .i_rst_n               (i_rst_n),
        .push                  (push),
        .full                  (full),
        .i_divider_millivolts  (i_divider_millivolts),
        .empty                 (empty),
        .pop                   (pop),
        .o_temperature_centi_c (o_temperature_centi_c),
        .o_resistance_ohms     (o_resistance_ohms),
        .o_status              (o_status),
        .i_cfg_we              (i_cfg_we),
        .i_cfg_index           (i_cfg_index),
        .i_cfg_data            (i_cfg_data)
    );

    always #5 i_clk = ~i_clk;

    // Sample both handshakes at the rising edge; inputs only move on the falling edge.
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (push && !full)
                sb.note_sample(i_divider_millivolts);
            if (pop && !empty)
                sb.check_result({o_temperature_centi_c, o_resistance_ohms,
                                 tdt_pkg::t_status'(o_status)});
        end
    end

    // Receiver: switch between free flow, coin-flip pops, long stalls and light stalls.
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            pop <= 1'b0;
        end else begin
            if (pop_mode_left == 0) begin
                pop_mode = $urandom_range(0, 3);
                pop_mode_left = $urandom_range(20, 200);
            end else begin
                pop_mode_left--;
            end
            unique case (pop_mode)
                0: pop <= 1'b1;
                1: pop <= 1'($urandom_range(0, 1));
                2: pop <= ($urandom_range(0, 7) == 0);
                default: pop <= ($urandom_range(0, 3) != 0);
            endcase
        end
    end

    // Present one sample and hold it until the block takes it; close a burst with a gap.
    task automatic send_sample(logic [tdt_pkg::MV_W-1:0] mv);
        int gap;
        @(negedge i_clk);
        push <= 1'b1;
        i_divider_millivolts <= mv;
        do @(posedge i_clk); while (full);
        burst_left--;
        if (burst_left <= 0) begin
            gap = $urandom_range(1, 12);
            burst_left = $urandom_range(1, 30);
            @(negedge i_clk);
            push <= 1'b0;
            i_divider_millivolts <= 16'($urandom);
            repeat (gap - 1) @(negedge i_clk);
        end
    endtask

    // Drop push and wait until every outstanding reading has been popped.
    task automatic drain();
        @(negedge i_clk);
        push <= 1'b0;
        while (sb.readings_due.size() != 0)
            @(posedge i_clk);
        repeat (200) @(posedge i_clk);
    endtask

    task automatic write_reg(tdt_pkg::t_cfg_idx idx, logic [tdt_pkg::CFG_DATA_W-1:0] d);
        @(negedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= d;
        @(posedge i_clk);
        sb.write_reg(idx, d);
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    task automatic load_all(logic [tdt_pkg::CFG_DATA_W-1:0] rs,
                            logic [tdt_pkg::CFG_DATA_W-1:0] vr,
                            logic [47:0] a, logic [47:0] b, logic [47:0] c, bit ok);
        write_reg(tdt_pkg::CFG_SERIES_R, rs);
        write_reg(tdt_pkg::CFG_REF_MV, vr);
        write_reg(tdt_pkg::CFG_COEFF_A, a);
        write_reg(tdt_pkg::CFG_COEFF_B, b);
        write_reg(tdt_pkg::CFG_COEFF_C, c);
        write_reg(tdt_pkg::CFG_VALID, {47'($urandom), ok});
    endtask

    function automatic logic [47:0] jitter(logic [47:0] nom, int bits);
        logic [47:0] delta;
        delta = 48'({$urandom, $urandom}) & ((48'd1 << bits) - 1);
        return ($urandom_range(0, 1) != 0) ? nom + delta : nom - delta;
    endfunction

    // Mostly divider voltages inside the useful range, some anywhere in 16 bits.
    function automatic logic [tdt_pkg::MV_W-1:0] pick_mv();
        int vr;
        vr = sb.vr;
        unique case ($urandom_range(0, 9))
            0, 1: return 16'($urandom);
            2:    return 16'($urandom_range(0, 3));
            3:    return (vr > 4) ? 16'($urandom_range(vr - 4, vr)) : 16'($urandom_range(0, 4));
            default: return (vr > 2) ? 16'($urandom_range(0, vr - 2))
                                     : 16'($urandom_range(0, 3));
        endcase
    endfunction

    initial begin
        logic [47:0] ra, rb, rc;
        int corner_mv [12];
        corner_mv = '{0, 1, 2, 100, 1650, 3000, 3297, 3298, 3299, 3300, 65535, 32768};
        repeat (7) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Reset registers: no coefficients loaded yet.
        send_sample(16'd0);
        send_sample(16'd1650);
        send_sample(16'hFFFF);
        drain();

        // Nominal thermistor; high bits above the register width are masked off.
        write_reg(3'd6, 48'hFFFF_FFFF_FFFF);
        write_reg(3'd7, 48'h1234_5678_9ABC);
        load_all(48'hFF00_0000_2710, 48'hABCD_0000_0CE4, NOM_A, NOM_B, NOM_C, 1'b1);
        foreach (corner_mv[i])
            send_sample(16'(corner_mv[i]));
        drain();

        // Zero resistor, then zero reference.
        write_reg(tdt_pkg::CFG_SERIES_R, 48'd0);
        send_sample(16'd1000);
        send_sample(16'd0);
        drain();
        write_reg(tdt_pkg::CFG_SERIES_R, 48'd10000);
        write_reg(tdt_pkg::CFG_REF_MV, 48'd0);
        send_sample(16'd0);
        send_sample(16'd5);
        drain();

        // Largest resistor and reference: resistance saturates near the top.
        load_all(48'hFFFFFF, 48'hFFFF, NOM_A, NOM_B, NOM_C, 1'b1);
        send_sample(16'd65533);
        send_sample(16'd65000);
        send_sample(16'd65534);
        drain();

        // Negative 1/T, then a tiny positive 1/T that saturates the temperature.
        load_all(48'd10000, 48'd3300, 48'h8000_0000_0000, 48'h8000_0000_0000,
                 48'h8000_0000_0000, 1'b1);
        send_sample(16'd1650);
        drain();
        load_all(48'd10000, 48'd3300, 48'd1, 48'd0, 48'd0, 1'b1);
        send_sample(16'd1650);
        drain();
        write_reg(tdt_pkg::CFG_COEFF_A, 48'h7FFF_FFFF_FFFF);
        write_reg(tdt_pkg::CFG_COEFF_C, 48'h7FFF_FFFF_FFFF);
        send_sample(16'd1650);
        drain();

        // Random phases: coefficients rotate through jittered nominal, random, small and nominal sets.
        for (int ph = 0; ph < 7; ph++) begin
            unique case (ph % 4)
                0: begin
                    ra = jitter(NOM_A, 38);
                    rb = jitter(NOM_B, 34);
                    rc = jitter(NOM_C, 24);
                end
                1: begin
                    ra = 48'({$urandom, $urandom});
                    rb = 48'({$urandom, $urandom});
                    rc = 48'({$urandom, $urandom});
                end
                2: begin
                    ra = jitter(48'd0, 20);
                    rb = jitter(48'd0, 12);
                    rc = jitter(48'd0, 8);
                end
                default: begin
                    ra = NOM_A;
                    rb = NOM_B;
                    rc = NOM_C;
                end
            endcase
            load_all(($urandom_range(0, 2) == 0) ? 48'($urandom)
                                                 : 48'($urandom_range(100, 200000)),
                     ($urandom_range(0, 2) == 0) ? 48'($urandom)
                                                 : 48'($urandom_range(1000, 5000)),
                     ra, rb, rc, (ph != 5));
            repeat (90) send_sample(pick_mv());
            drain();
        end

        if (sb.mismatches == 0 && sb.readings_due.size() == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

    initial begin
        #2000000;
        $display("Simulation FAILED");
        $finish;
    end

endmodule

@@ filelist.f @@
+incdir+design
design/tdt_pkg.sv
design/tdt_front.sv
design/tdt_fifo.sv
design/tdt_back.sv
design/thermistor_divider_to_temperature.sv
tb/sv/thermistor_divider_to_temperature_test.sv
